// File: hdl/lfdr_pkg.sv
// lfdr_pkg: shared types, codes and helper functions for the lcd frame store block
// no dependencies; compile first

package lfdr_pkg;

  localparam int KIND_W = 2;
  localparam int X_W    = 7;
  localparam int Y_W    = 6;
  localparam int BYTE_W = 8;
  localparam int SEG_N  = 16;
  localparam int SEG_W  = 4;

  // item kinds
  localparam logic [KIND_W-1:0] KIND_SET  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_GET  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_TICK = 2'd2;

  // panel commands
  localparam logic [BYTE_W-1:0] PAGE_CMD   = 8'hB8;
  localparam logic [BYTE_W-1:0] COLUMN_CMD = 8'h40;

  // frame store access control
  typedef struct packed {
    logic rd;
    logic wr;
  } store_ctl_t;

  // result of the dirty segment priority search
  typedef struct packed {
    logic             found;
    logic [SEG_W-1:0] idx;
  } seg_pick_t;

  // segments that exist for a given page count (both halves)
  function automatic logic [SEG_N-1:0] valid_mask(input int pages);
    logic [SEG_N-1:0] m;
    m = '0;
    for (int p = 0; p < 8; p++) begin
      if (p < pages) begin
        m[p]     = 1'b1;
        m[p + 8] = 1'b1;
      end
    end
    return m;
  endfunction

  // lowest set bit of the dirty vector
  function automatic seg_pick_t lowest_dirty(input logic [SEG_N-1:0] d);
    seg_pick_t r;
    r.found = 1'b0;
    r.idx   = '0;
    for (int s = SEG_N - 1; s >= 0; s--) begin
      if (d[s]) begin
        r.found = 1'b1;
        r.idx   = SEG_W'(s);
      end
    end
    return r;
  endfunction

endpackage

// File: hdl/lfdr_req_if.sv
// lfdr_req_if: request channel (set pixel, get pixel, refresh tick)
// depends on lfdr_pkg

interface lfdr_req_if;
  import lfdr_pkg::*;

  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [X_W-1:0]    x;
  logic [Y_W-1:0]    y;
  logic              pixel_in;

  modport source (output valid, kind, x, y, pixel_in, input ready);
  modport sink   (input valid, kind, x, y, pixel_in, output ready);
endinterface

// File: hdl/lfdr_rsp_if.sv
// lfdr_rsp_if: result channel (pixel reply or panel bus transfer)
// depends on lfdr_pkg

interface lfdr_rsp_if;
  import lfdr_pkg::*;

  logic              valid;
  logic              ready;
  logic              is_bus;
  logic              pixel_out;
  logic              bus_is_data;
  logic              half_select;
  logic [BYTE_W-1:0] bus_byte;
  logic              last;

  modport source (output valid, is_bus, pixel_out, bus_is_data, half_select, bus_byte, last,
                  input ready);
  modport sink   (input valid, is_bus, pixel_out, bus_is_data, half_select, bus_byte, last,
                  output ready);
endinterface

// File: hdl/lfdr_store.sv
// lfdr_store: byte-wide frame store, one access per cycle, registered read data
// clears itself to zero after reset, one entry per cycle; depends on lfdr_pkg

module lfdr_store #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic                clk,
  input  logic                rst,
  input  lfdr_pkg::store_ctl_t ctl,
  input  logic [AW-1:0]       addr,
  input  logic [7:0]          wdata,
  output logic [7:0]          rdata,
  output logic                clearing
);
  import lfdr_pkg::*;

  logic [BYTE_W-1:0] mem [DEPTH];
  logic [AW-1:0]     clr_addr;
  logic              clr_busy;

  assign clearing = clr_busy;

  // clear sweep
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_addr <= '0;
    end else if (clr_busy) begin
      if (clr_addr == AW'(DEPTH - 1)) begin
        clr_busy <= 1'b0;
      end else begin
        clr_addr <= clr_addr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clr_busy) begin
      mem[clr_addr] <= '0;
    end else if (ctl.wr) begin
      mem[addr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd) begin
      rdata <= mem[addr];
    end
  end

endmodule

// File: hdl/lcd_framebuffer_dirty_refresh.sv
// lcd_framebuffer_dirty_refresh: shadow frame store with dirty segment refresh for a
// two-controller monochrome lcd; uses lfdr_pkg, lfdr_req_if, lfdr_rsp_if, lfdr_store

// The frame store holds PAGES pages of COLUMNS bytes, bit y%8 of byte [y/8][x] is the
// pixel. A set-pixel item writes one bit and marks its (page, half) segment dirty when the
// bit really changes; a get-pixel item returns the stored bit; each refresh tick returns one
// panel bus transfer of the lowest dirty segment, if any (page command, column command, then
// COLUMNS/2 data bytes read at the moment they go out), with last set on the final byte
// of a pass. Items are handled one at a time: the store is read as an item is accepted,
// and the item is then modified, written back and its result registered in the execute
// state, since the store has registered read data. The next item is taken while a finished
// result still waits in the output register; only an item that itself has a result waits
// for that register to drain. After reset the store clears itself and takes no item in that
// time; the full_refresh register is written through cfg_write/cfg_data at any time.

module lcd_framebuffer_dirty_refresh #(
  parameter int PAGES   = 8,
  parameter int COLUMNS = 128
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic       cfg_data,
  lfdr_req_if.sink   req,
  lfdr_rsp_if.source rsp
);
  import lfdr_pkg::*;

  localparam int HALF   = COLUMNS / 2;
  localparam int DEPTH  = PAGES * COLUMNS;
  localparam int AW     = $clog2(DEPTH);
  localparam int STEP_W = $clog2(HALF + 2);
  localparam logic [SEG_N-1:0] VALID_MASK = valid_mask(PAGES);
  localparam logic [8:0]       COL_LIM    = 9'(2 * HALF);
  localparam logic [8:0]       HALF_COL   = 9'(HALF);

  // sequencer states
  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  // what the execute state does with the item
  localparam logic [2:0] OP_NONE = 3'd0;
  localparam logic [2:0] OP_SET  = 3'd1;
  localparam logic [2:0] OP_GET  = 3'd2;
  localparam logic [2:0] OP_CMD  = 3'd3;
  localparam logic [2:0] OP_DATA = 3'd4;

  // control state
  logic              state;
  logic              full_refresh;
  logic              busy;
  logic [SEG_W-1:0]  cur_seg;
  logic [STEP_W-1:0] step;
  logic [SEG_N-1:0]  dirty;
  logic              out_valid;

  // item held between its read and its execute state
  logic [2:0]        op_lat;
  logic [AW-1:0]     addr_lat;
  logic [2:0]        bit_lat;
  logic              want_lat;
  logic              pix_ok_lat;
  logic [SEG_W-1:0]  seg_lat;
  logic [BYTE_W-1:0] cmd_lat;
  logic              last_lat;

  // output register payload
  logic              o_is_bus;
  logic              o_pixel;
  logic              o_is_data;
  logic              o_half;
  logic [BYTE_W-1:0] o_byte;
  logic              o_last;

  // store port
  store_ctl_t        st_ctl;
  logic [AW-1:0]     st_addr;
  logic [BYTE_W-1:0] st_wdata;
  logic [BYTE_W-1:0] st_rdata;
  logic              st_clearing;

  // accept side decode
  logic              accept;
  logic [2:0]        pg;
  logic              pix_ok;
  logic              pix_half;
  logic [AW-1:0]     pix_addr;
  logic              start;
  logic [SEG_N-1:0]  dirty_start;
  seg_pick_t         pick_start;
  seg_pick_t         pick_end;
  logic              tick_idle;
  logic [SEG_W-1:0]  seg_sel;
  logic [STEP_W-1:0] step_sel;
  logic              seg_done;
  logic [AW-1:0]     data_addr;
  logic [2:0]        op_sel;
  logic [BYTE_W-1:0] cmd_sel;

  // execute state
  logic              has_result;
  logic              stall;
  logic              bit_change;

  lfdr_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk      (clk),
    .rst      (rst),
    .ctl      (st_ctl),
    .addr     (st_addr),
    .wdata    (st_wdata),
    .rdata    (st_rdata),
    .clearing (st_clearing)
  );

  assign req.ready = (state == ST_IDLE) && !st_clearing;
  assign accept    = req.valid && req.ready;

  // pixel addressing; out of range columns or pages are flagged
  assign pg       = req.y[5:3];
  assign pix_ok   = ({2'b00, req.x} < COL_LIM) && ({1'b0, pg} < 4'(PAGES));
  assign pix_half = ({2'b00, req.x} >= HALF_COL);
  assign pix_addr = AW'(pg) * AW'(COLUMNS) + AW'(req.x);

  // refresh pass bookkeeping: a tick while idle may start a pass
  assign start       = !busy;
  assign dirty_start = (start && full_refresh) ? (dirty | VALID_MASK) : dirty;
  assign pick_start  = lowest_dirty(dirty_start & VALID_MASK);
  assign pick_end    = lowest_dirty(dirty & VALID_MASK);
  assign tick_idle   = start && !pick_start.found;
  assign seg_sel     = start ? pick_start.idx : cur_seg;
  assign step_sel    = start ? '0 : step;
  assign seg_done    = (step_sel == STEP_W'(HALF + 1));
  assign data_addr   = AW'(seg_sel[2:0]) * AW'(COLUMNS)
                     + (seg_sel[3] ? AW'(HALF) : '0)
                     + AW'(step_sel - STEP_W'(2));

  always_comb begin
    op_sel  = OP_NONE;
    cmd_sel = COLUMN_CMD;
    case (req.kind)
      KIND_SET: op_sel = OP_SET;
      KIND_GET: op_sel = OP_GET;
      KIND_TICK: begin
        if (!tick_idle) begin
          if (step_sel == STEP_W'(0)) begin
            op_sel  = OP_CMD;
            cmd_sel = PAGE_CMD | {5'b00000, seg_sel[2:0]};
          end else if (step_sel == STEP_W'(1)) begin
            op_sel = OP_CMD;
          end else begin
            op_sel = OP_DATA;
          end
        end
      end
      default: op_sel = OP_NONE;
    endcase
  end

  // execute state: result slot and write back
  assign has_result = (op_lat == OP_GET) || (op_lat == OP_CMD) || (op_lat == OP_DATA);
  assign stall      = has_result && out_valid && !rsp.ready;
  assign bit_change = pix_ok_lat && (st_rdata[bit_lat] != want_lat);

  always_comb begin
    st_wdata          = st_rdata;
    st_wdata[bit_lat] = want_lat;
  end

  assign st_ctl.rd = accept;
  assign st_ctl.wr = (state == ST_EXEC) && !stall && (op_lat == OP_SET) && bit_change;
  assign st_addr   = (state == ST_EXEC) ? addr_lat
                   : ((req.kind == KIND_TICK) ? data_addr : pix_addr);

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      full_refresh <= 1'b0;
      busy         <= 1'b0;
      cur_seg      <= '0;
      step         <= '0;
      dirty        <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_write) begin
        full_refresh <= cfg_data;
      end
      if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= ST_EXEC;
            if (req.kind == KIND_TICK) begin
              dirty <= dirty_start;
              if (!tick_idle) begin
                busy <= 1'b1;
                if (step_sel == STEP_W'(0)) begin
                  // segment starts: its dirty bit clears now
                  dirty   <= dirty_start & ~(SEG_N'(1) << seg_sel);
                  cur_seg <= seg_sel;
                  step    <= STEP_W'(1);
                end else if (seg_done) begin
                  // last byte of the segment: pick the next or end the pass
                  step <= '0;
                  if (pick_end.found) begin
                    cur_seg <= pick_end.idx;
                  end else begin
                    busy <= 1'b0;
                  end
                end else begin
                  step <= step_sel + 1'b1;
                end
              end
            end
          end
        end
        ST_EXEC: begin
          if (!stall) begin
            state <= ST_IDLE;
            if ((op_lat == OP_SET) && bit_change) begin
              dirty <= dirty | (SEG_N'(1) << seg_lat);
            end
            if (has_result) begin
              out_valid <= 1'b1;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // item latch
  always_ff @(posedge clk) begin
    if (accept) begin
      op_lat     <= op_sel;
      addr_lat   <= (req.kind == KIND_TICK) ? data_addr : pix_addr;
      bit_lat    <= req.y[2:0];
      want_lat   <= req.pixel_in;
      pix_ok_lat <= pix_ok;
      seg_lat    <= (req.kind == KIND_TICK) ? seg_sel : {pix_half, pg};
      cmd_lat    <= cmd_sel;
      last_lat   <= seg_done && !pick_end.found;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if ((state == ST_EXEC) && !stall && has_result) begin
      o_is_bus  <= (op_lat == OP_CMD) || (op_lat == OP_DATA);
      o_pixel   <= (op_lat == OP_GET) && pix_ok_lat && st_rdata[bit_lat];
      o_is_data <= (op_lat == OP_DATA);
      o_half    <= (op_lat != OP_GET) && seg_lat[3];
      o_last    <= (op_lat == OP_DATA) && last_lat;
      case (op_lat)
        OP_CMD:  o_byte <= cmd_lat;
        OP_DATA: o_byte <= st_rdata;
        default: o_byte <= '0;
      endcase
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.is_bus      = o_is_bus;
  assign rsp.pixel_out   = o_pixel;
  assign rsp.bus_is_data = o_is_data;
  assign rsp.half_select = o_half;
  assign rsp.bus_byte    = o_byte;
  assign rsp.last        = o_last;

endmodule

// File: bench/lcd_framebuffer_dirty_refresh_tb.sv
`timescale 1ns / 100ps
// testbench for lcd_framebuffer_dirty_refresh: a directed table, then random set, get and
// refresh items, scored against typed results or an in-bench frame store predictor
// depends on lfdr_pkg, lfdr_req_if, lfdr_rsp_if and the block itself

module lcd_framebuffer_dirty_refresh_tb;
  import lfdr_pkg::*;

  // panel geometry, kept at the block's defaults
  localparam int PAGES   = 8;
  localparam int COLUMNS = 128;
  localparam int HALF    = COLUMNS / 2;

  // with 8 pages every segment of both halves exists
  localparam logic [SEG_N-1:0] ALL_SEGMENTS = 16'hFFFF;

  // the one kind code the block ignores
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  localparam int IDLE_PCT       = 20;    // chance of a gap or stall per item or cycle
  localparam int SETTLE_CYCLES  = 8;     // lets an item without a result leave the block
  localparam int HOLD_AT_RESULT = 600;   // results seen before the long receiver hold-off
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 6000;  // covers the store clear after reset

  // one request item as it goes onto the request channel
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [X_W-1:0]    x;
    logic [Y_W-1:0]    y;
    logic              pixel_in;
  } pixel_req_t;

  // one result item: a pixel reply or a panel bus transfer
  typedef struct packed {
    logic              is_bus;
    logic              pixel_out;
    logic              bus_is_data;
    logic              half_select;
    logic [BYTE_W-1:0] bus_byte;
    logic              last;
  } panel_out_t;

  // how a directed row is scored
  typedef enum logic [1:0] {
    CHK_PREDICT,    // whatever the predictor says
    CHK_NO_RESULT,  // no result at all
    CHK_TYPED       // exactly the result typed into the row
  } row_check_t;

  typedef struct packed {
    pixel_req_t  req;
    row_check_t  chk;
    panel_out_t  want;
  } table_row_t;

  logic clk;
  logic rst;
  logic cfg_write;
  logic cfg_data;

  lfdr_req_if req_ch ();
  lfdr_rsp_if rsp_ch ();

  lcd_framebuffer_dirty_refresh #(
    .PAGES   (PAGES),
    .COLUMNS (COLUMNS)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  // ---------------------------------------------------------------------------------------
  // directed table
  // after reset everything reads 0 and a tick finds nothing dirty; then pixels go into the
  // four corner segments (left/right, top/bottom page), two sets repeat an unchanged value,
  // and the first refresh pass starts on segment 0 with its page and column commands. A pixel
  // is cleared while its segment is being sent, which dirties the segment again.
  // ---------------------------------------------------------------------------------------
  table_row_t directed_rows [22] = '{
    '{'{KIND_GET,    7'd0,   6'd0,  1'b0}, CHK_TYPED,     '{1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0}},
    '{'{KIND_GET,    7'd127, 6'd63, 1'b0}, CHK_TYPED,     '{1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0}},
    '{'{KIND_TICK,   7'd0,   6'd0,  1'b0}, CHK_NO_RESULT, '0},
    '{'{KIND_UNUSED, 7'd127, 6'd63, 1'b1}, CHK_NO_RESULT, '0},
    '{'{KIND_SET,    7'd0,   6'd0,  1'b1}, CHK_NO_RESULT, '0},
    '{'{KIND_SET,    7'd127, 6'd63, 1'b1}, CHK_NO_RESULT, '0},
    '{'{KIND_SET,    7'd127, 6'd63, 1'b1}, CHK_NO_RESULT, '0},
    '{'{KIND_GET,    7'd0,   6'd0,  1'b0}, CHK_TYPED,     '{1'b0, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0}},
    '{'{KIND_GET,    7'd127, 6'd63, 1'b0}, CHK_TYPED,     '{1'b0, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0}},
    '{'{KIND_SET,    7'd64,  6'd7,  1'b1}, CHK_NO_RESULT, '0},
    '{'{KIND_SET,    7'd63,  6'd56, 1'b1}, CHK_NO_RESULT, '0},
    '{'{KIND_SET,    7'd5,   6'd5,  1'b0}, CHK_NO_RESULT, '0},
    '{'{KIND_TICK,   7'd0,   6'd0,  1'b0}, CHK_TYPED,     '{1'b1, 1'b0, 1'b0, 1'b0, 8'hB8, 1'b0}},
    '{'{KIND_TICK,   7'd0,   6'd0,  1'b0}, CHK_TYPED,     '{1'b1, 1'b0, 1'b0, 1'b0, 8'h40, 1'b0}},
    '{'{KIND_TICK,   7'd0,   6'd0,  1'b0}, CHK_TYPED,     '{1'b1, 1'b0, 1'b1, 1'b0, 8'h01, 1'b0}},
    '{'{KIND_TICK,   7'd0,   6'd0,  1'b0}, CHK_PREDICT,   '0},
    '{'{KIND_SET,    7'd0,   6'd0,  1'b0}, CHK_NO_RESULT, '0},
    '{'{KIND_GET,    7'd0,   6'd0,  1'b0}, CHK_TYPED,     '{1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0}},
    '{'{KIND_GET,    7'd64,  6'd7,  1'b0}, CHK_TYPED,     '{1'b0, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0}},
    '{'{KIND_TICK,   7'd0,   6'd0,  1'b0}, CHK_PREDICT,   '0},
    '{'{KIND_SET,    7'd1,   6'd0,  1'b1}, CHK_NO_RESULT, '0},
    '{'{KIND_TICK,   7'd0,   6'd0,  1'b0}, CHK_PREDICT,   '0}
  };

  // ---------------------------------------------------------------------------------------
  // predictor state: a shadow copy of the frame store, dirty flags and refresh sequencer
  // ---------------------------------------------------------------------------------------
  logic [BYTE_W-1:0] shadow_frame [PAGES*COLUMNS];
  logic [SEG_N-1:0]  shadow_dirty;
  logic              shadow_busy;
  logic [SEG_W-1:0]  shadow_seg;
  int                shadow_step;          // 0 page cmd, 1 column cmd, 2.. data bytes
  logic              shadow_full_refresh;

  panel_out_t pending_outputs [$];         // results owed by the block, oldest first
  int         mismatch_count = 0;
  int         results_seen   = 0;
  logic       sender_gaps    = 1'b1;

  function automatic int lowest_dirty_segment();
    for (int s = 0; s < SEG_N; s++) begin
      if (shadow_dirty[s]) return s;
    end
    return -1;
  endfunction

  // advances the shadow state by one accepted item; returns 1 when a result is owed
  function automatic logic predict_panel_out(input pixel_req_t it, output panel_out_t r);
    int         pg;
    int         col;
    int         hf;
    int         addr;
    int         nxt;
    logic [2:0] bit_i;
    r     = '0;
    pg    = int'(it.y) >> 3;
    col   = int'(it.x);
    hf    = (col >= HALF) ? 1 : 0;
    addr  = pg * COLUMNS + col;
    bit_i = it.y[2:0];
    case (it.kind)
      KIND_SET: begin
        // only a real change of the bit marks the segment dirty
        if (pg < PAGES && col < 2 * HALF && shadow_frame[addr][bit_i] != it.pixel_in) begin
          shadow_frame[addr][bit_i] = it.pixel_in;
          shadow_dirty[pg + 8 * hf] = 1'b1;
        end
        return 1'b0;
      end
      KIND_GET: begin
        if (pg < PAGES && col < 2 * HALF) r.pixel_out = shadow_frame[addr][bit_i];
        return 1'b1;
      end
      KIND_TICK: begin
        // a tick while idle opens a pass, or does nothing when no segment is dirty
        if (!shadow_busy) begin
          if (shadow_full_refresh) shadow_dirty = shadow_dirty | ALL_SEGMENTS;
          nxt = lowest_dirty_segment();
          if (nxt < 0) return 1'b0;
          shadow_busy = 1'b1;
          shadow_seg  = SEG_W'(nxt);
          shadow_step = 0;
        end
        pg            = int'(shadow_seg[2:0]);
        hf            = int'(shadow_seg[3]);
        r.is_bus      = 1'b1;
        r.half_select = shadow_seg[3];
        if (shadow_step == 0) begin
          shadow_dirty[shadow_seg] = 1'b0;
          r.bus_byte  = PAGE_CMD | BYTE_W'(pg);
          shadow_step = 1;
        end else if (shadow_step == 1) begin
          r.bus_byte  = COLUMN_CMD;
          shadow_step = 2;
        end else begin
          // data bytes are read at the moment they go out
          r.bus_is_data = 1'b1;
          r.bus_byte    = shadow_frame[pg * COLUMNS + hf * HALF + shadow_step - 2];
          if (shadow_step - 1 >= HALF) begin
            nxt = lowest_dirty_segment();
            if (nxt < 0) begin
              shadow_busy = 1'b0;
              r.last      = 1'b1;
            end else begin
              shadow_seg = SEG_W'(nxt);
            end
            shadow_step = 0;
          end else begin
            shadow_step = shadow_step + 1;
          end
        end
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // mostly well-formed traffic: writes cluster on one hot segment so passes stay short
  // and reach their last byte; the rest of the writes land anywhere on the panel
  function automatic pixel_req_t random_request(input int hot_seg);
    pixel_req_t it;
    int         pick;
    it.x        = X_W'($urandom_range(127));
    it.y        = Y_W'($urandom_range(63));
    it.pixel_in = 1'($urandom_range(1));
    pick        = $urandom_range(99);
    if (pick < 3) begin
      it.kind = KIND_UNUSED;
    end else if (pick < 30) begin
      it.kind = KIND_SET;
      if ($urandom_range(99) < 75) begin
        it.x = X_W'((hot_seg / 8) * HALF + $urandom_range(HALF - 1));
        it.y = Y_W'((hot_seg % 8) * 8 + $urandom_range(7));
      end
    end else if (pick < 42) begin
      it.kind = KIND_GET;
    end else begin
      it.kind = KIND_TICK;
    end
    return it;
  endfunction

  // ---------------------------------------------------------------------------------------
  // clock
  // ---------------------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------------------------
  // request side: called at a rising edge, returns at the edge the item is accepted
  // ---------------------------------------------------------------------------------------
  task automatic offer_request(input pixel_req_t it, input row_check_t chk,
                               input panel_out_t want);
    panel_out_t predicted;
    logic       has_out;
    if (sender_gaps && $urandom_range(99) < IDLE_PCT) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    req_ch.valid    <= 1'b1;
    req_ch.kind     <= it.kind;
    req_ch.x        <= it.x;
    req_ch.y        <= it.y;
    req_ch.pixel_in <= it.pixel_in;
    @(posedge clk);
    while (req_ch.ready !== 1'b1) @(posedge clk);
    // accepted at this edge: the predictor moves in step with the block
    has_out = predict_panel_out(it, predicted);
    if (chk == CHK_PREDICT) begin
      if (has_out) pending_outputs.push_back(predicted);
    end else if (chk == CHK_TYPED) begin
      pending_outputs.push_back(want);
    end
  endtask

  // wait until every owed result is out and any result-less item has left the block
  task automatic drain_and_settle();
    req_ch.valid <= 1'b0;
    while (pending_outputs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_refresh_mode(input logic mode);
    cfg_write <= 1'b1;
    cfg_data  <= mode;
    @(posedge clk);
    cfg_write           <= 1'b0;
    shadow_full_refresh  = mode;
  endtask

  task automatic run_random_phase(input int count, input logic mode);
    int hot;
    drain_and_settle();
    write_refresh_mode(mode);
    hot = $urandom_range(SEG_N - 1);
    for (int i = 0; i < count; i++) begin
      if (i % 100 == 99) hot = $urandom_range(SEG_N - 1);
      // a stretch of back-to-back items in the longer phases
      sender_gaps = !(i >= 250 && i < 400);
      offer_request(random_request(hot), CHK_PREDICT, '0);
    end
  endtask

  // ---------------------------------------------------------------------------------------
  // stimulus: reset, directed table, then four random phases that toggle full refresh
  // ---------------------------------------------------------------------------------------
  initial begin : stimulus
    rst             <= 1'b1;
    cfg_write       <= 1'b0;
    cfg_data        <= 1'b0;
    req_ch.valid    <= 1'b0;
    req_ch.kind     <= KIND_SET;
    req_ch.x        <= '0;
    req_ch.y        <= '0;
    req_ch.pixel_in <= 1'b0;
    foreach (shadow_frame[i]) shadow_frame[i] = '0;
    shadow_dirty        = '0;
    shadow_busy         = 1'b0;
    shadow_seg          = '0;
    shadow_step         = 0;
    shadow_full_refresh = 1'b0;

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    // the block clears its store now; requests simply wait for ready
    write_refresh_mode(1'b0);

    foreach (directed_rows[i]) begin
      offer_request(directed_rows[i].req, directed_rows[i].chk, directed_rows[i].want);
    end

    run_random_phase(650, 1'b0);
    run_random_phase(650, 1'b1);
    run_random_phase(200, 1'b0);
    run_random_phase(130, 1'b1);

    drain_and_settle();
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------------------
  // result side: random stalls, one long hold-off, and scoring of each accepted item
  // ---------------------------------------------------------------------------------------
  task automatic compare_field(input string name, input logic [BYTE_W-1:0] want,
                               input logic [BYTE_W-1:0] got);
    if (got !== want) begin
      mismatch_count++;
      $display("%0t: %s expected %0h got %0h", $realtime, name, want, got);
    end
  endtask

  task automatic check_panel_out();
    panel_out_t want;
    results_seen++;
    if (pending_outputs.size() == 0) begin
      mismatch_count++;
      $display("%0t: result expected none got bus %0b byte %0h", $realtime,
               rsp_ch.is_bus, rsp_ch.bus_byte);
      return;
    end
    want = pending_outputs.pop_front();
    compare_field("is_bus", BYTE_W'(want.is_bus), BYTE_W'(rsp_ch.is_bus));
    compare_field("pixel_out", BYTE_W'(want.pixel_out), BYTE_W'(rsp_ch.pixel_out));
    compare_field("bus_is_data", BYTE_W'(want.bus_is_data), BYTE_W'(rsp_ch.bus_is_data));
    compare_field("half_select", BYTE_W'(want.half_select), BYTE_W'(rsp_ch.half_select));
    compare_field("bus_byte", want.bus_byte, rsp_ch.bus_byte);
    compare_field("last", BYTE_W'(want.last), BYTE_W'(rsp_ch.last));
  endtask

  initial begin : result_sink
    int   hold_left;
    logic held_once;
    hold_left = 0;
    held_once = 1'b0;
    rsp_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      // one long hold-off: requests keep coming until the block backs up
      if (!held_once && results_seen >= HOLD_AT_RESULT) begin
        held_once = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        rsp_ch.ready <= 1'b0;
        hold_left--;
      end else if (results_seen >= 200 && results_seen < 350) begin
        rsp_ch.ready <= 1'b1;   // no stalls over this stretch
      end else begin
        rsp_ch.ready <= ($urandom_range(99) >= IDLE_PCT);
      end
      @(posedge clk);
      if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) check_panel_out();
    end
  end

  // ---------------------------------------------------------------------------------------
  // watchdog: too long without any item moving on either channel ends the run
  // ---------------------------------------------------------------------------------------
  int idle_cycles = 0;

  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
